@@ hw/rtl/ebm_pkg.sv @@
// Shared types and constants for the ext2 block map translator.
package ebm_pkg;

  localparam int unsigned BLOCK_BYTES     = 1024;
  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned DIRECT_POINTERS = 12;
  localparam int unsigned PTRS_PER_BLOCK  = 256;
  localparam int unsigned DOUBLE_SPAN     = 65536;
  localparam int unsigned NUM_SLOTS       = 15;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // first block index of each indirect tier
  localparam int unsigned SINGLE_BASE = DIRECT_POINTERS;
  localparam int unsigned DOUBLE_BASE = SINGLE_BASE + PTRS_PER_BLOCK;
  localparam int unsigned TRIPLE_BASE = DOUBLE_BASE + DOUBLE_SPAN;

  localparam logic [3:0] SLOT_SINGLE = 4'd12;
  localparam logic [3:0] SLOT_DOUBLE = 4'd13;
  localparam logic [3:0] SLOT_TRIPLE = 4'd14;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_XLATE = 2'd1;
  localparam logic [1:0] REQ_RESP  = 2'd2;

  // result kinds (an out-of-range error cannot occur with 32-bit offsets)
  localparam logic [1:0] KIND_PTR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic [31:0] word;
    logic [31:0] file_offset;
    logic [10:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [22:0] sector;
    logic [8:0]  sector_offset;
    logic [9:0]  length;
    logic [10:0] dest_offset;
    logic        last;
  } out_item_t;

  typedef enum logic [0:0] {
    JOB_PTR,
    JOB_DATA
  } job_kind_t;

  // one unit of work for the back end; addr is the card byte address
  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] addr;
    logic [10:0] size;
    logic [10:0] dest;
    logic        last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PIECE,
    FS_CHASE
  } front_state_t;

  typedef enum logic [1:0] {
    BK_EMPTY,
    BK_HEAD,
    BK_TAIL
  } back_state_t;

endpackage

@@ hw/rtl/ebm_front.sv @@
// Front end: pointer table, request decode and indirect chase sequencer.
module ebm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ebm_pkg::in_item_t   in_item,
  output ebm_pkg::job_push_t  q_wr,
  input  logic                q_full
);
  import ebm_pkg::*;

  front_state_t state_r, state_nxt;
  logic         phase_wait_r, phase_wait_nxt;
  logic [1:0]   levels_r, levels_nxt;
  logic [15:0]  rem_r, rem_nxt;
  logic [31:0]  block_r, block_nxt;
  logic         have_blk_r, have_blk_nxt;
  logic [31:0]  piece_off_r, piece_off_nxt;
  logic [10:0]  piece_size_r, piece_size_nxt;
  logic         second_pend_r, second_pend_nxt;
  logic [10:0]  second_size_r, second_size_nxt;
  logic [10:0]  piece_dest_r, piece_dest_nxt;
  logic [31:0]  ptab_r [NUM_SLOTS];

  logic        acc;
  logic [21:0] idx, idx1, idx2, idx3;
  logic        is_direct, is_single, is_double;
  logic [3:0]  tab_addr;
  logic [31:0] tab_rd, data_blk;
  logic [10:0] cnt_sat, pre;
  logic [11:0] blk_sum;
  logic [7:0]  part;

  assign full = (state_r != FS_IDLE);
  assign acc  = push && !full;

  // tier classification of the current piece
  assign idx       = piece_off_r[31:10];
  assign idx1      = idx - 22'(SINGLE_BASE);
  assign idx2      = idx - 22'(DOUBLE_BASE);
  assign idx3      = idx - 22'(TRIPLE_BASE);
  assign is_direct = (idx < 22'(DIRECT_POINTERS));
  assign is_single = (idx1 < 22'(PTRS_PER_BLOCK));
  assign is_double = (idx2 < 22'(DOUBLE_SPAN));

  always_comb begin
    if (is_direct) begin
      tab_addr = idx[3:0];
    end else if (is_single) begin
      tab_addr = SLOT_SINGLE;
    end else if (is_double) begin
      tab_addr = SLOT_DOUBLE;
    end else begin
      tab_addr = SLOT_TRIPLE;
    end
  end

  assign tab_rd   = ptab_r[tab_addr];
  assign data_blk = have_blk_r ? block_r : tab_rd;

  // range split at the block boundary
  assign cnt_sat = (in_item.byte_count > 11'(BLOCK_BYTES)) ? 11'(BLOCK_BYTES)
                                                           : in_item.byte_count;
  assign blk_sum = {2'b00, in_item.file_offset[9:0]} + {1'b0, cnt_sat};
  assign pre     = 11'(BLOCK_BYTES) - {1'b0, in_item.file_offset[9:0]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (acc) begin
          if (in_item.req_type == REQ_XLATE && !phase_wait_r) begin
            state_nxt = FS_PIECE;
          end else if (in_item.req_type == REQ_RESP && phase_wait_r) begin
            state_nxt = (levels_r == 2'd0) ? FS_PIECE : FS_CHASE;
          end
        end
      end
      FS_PIECE: begin
        if (!q_full) begin
          if ((have_blk_r || is_direct) && second_pend_r) begin
            state_nxt = FS_PIECE;
          end else begin
            state_nxt = FS_IDLE;
          end
        end
      end
      FS_CHASE: begin
        if (!q_full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    phase_wait_nxt  = phase_wait_r;
    levels_nxt      = levels_r;
    rem_nxt         = rem_r;
    block_nxt       = block_r;
    have_blk_nxt    = have_blk_r;
    piece_off_nxt   = piece_off_r;
    piece_size_nxt  = piece_size_r;
    second_pend_nxt = second_pend_r;
    second_size_nxt = second_size_r;
    piece_dest_nxt  = piece_dest_r;
    part            = '0;
    q_wr            = '0;
    case (state_r)
      FS_IDLE: begin
        if (acc) begin
          case (in_item.req_type)
            REQ_XLATE: begin
              if (!phase_wait_r) begin
                piece_off_nxt  = in_item.file_offset;
                piece_dest_nxt = '0;
                have_blk_nxt   = 1'b0;
                if (blk_sum > 12'(BLOCK_BYTES)) begin
                  piece_size_nxt  = pre;
                  second_size_nxt = cnt_sat - pre;
                  second_pend_nxt = 1'b1;
                end else begin
                  piece_size_nxt  = cnt_sat;
                  second_size_nxt = '0;
                  second_pend_nxt = 1'b0;
                end
              end
            end
            REQ_RESP: begin
              if (phase_wait_r) begin
                block_nxt    = in_item.word;
                have_blk_nxt = (levels_r == 2'd0);
              end
            end
            default: ;
          endcase
        end
      end
      FS_PIECE: begin
        if (!q_full) begin
          q_wr.valid = 1'b1;
          if (have_blk_r || is_direct) begin
            q_wr.job.kind = JOB_DATA;
            q_wr.job.addr = {data_blk[21:0], piece_off_r[9:0]};
            q_wr.job.size = piece_size_r;
            q_wr.job.dest = piece_dest_r;
            q_wr.job.last = !second_pend_r;
            if (second_pend_r) begin
              piece_off_nxt   = piece_off_r + {21'b0, piece_size_r};
              piece_dest_nxt  = piece_size_r;
              piece_size_nxt  = second_size_r;
              second_pend_nxt = 1'b0;
              have_blk_nxt    = 1'b0;
            end else begin
              phase_wait_nxt = 1'b0;
            end
          end else begin
            phase_wait_nxt = 1'b1;
            if (is_single) begin
              part       = idx1[7:0];
              levels_nxt = 2'd0;
              rem_nxt    = '0;
            end else if (is_double) begin
              part       = idx2[15:8];
              levels_nxt = 2'd1;
              rem_nxt    = {8'b0, idx2[7:0]};
            end else begin
              part       = {2'b00, idx3[21:16]};
              levels_nxt = 2'd2;
              rem_nxt    = idx3[15:0];
            end
            q_wr.job.kind = JOB_PTR;
            q_wr.job.addr = {tab_rd[21:0], part, 2'b00};
          end
        end
      end
      FS_CHASE: begin
        if (!q_full) begin
          q_wr.valid = 1'b1;
          if (levels_r == 2'd2) begin
            part       = rem_r[15:8];
            rem_nxt    = {8'b0, rem_r[7:0]};
            levels_nxt = 2'd1;
          end else begin
            part       = rem_r[7:0];
            rem_nxt    = '0;
            levels_nxt = 2'd0;
          end
          q_wr.job.kind = JOB_PTR;
          q_wr.job.addr = {block_r[21:0], part, 2'b00};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= FS_IDLE;
      phase_wait_r  <= 1'b0;
      levels_r      <= '0;
      have_blk_r    <= 1'b0;
      second_pend_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_wait_r  <= phase_wait_nxt;
      levels_r      <= levels_nxt;
      have_blk_r    <= have_blk_nxt;
      second_pend_r <= second_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    block_r       <= block_nxt;
    piece_off_r   <= piece_off_nxt;
    piece_size_r  <= piece_size_nxt;
    second_size_r <= second_size_nxt;
    piece_dest_r  <= piece_dest_nxt;
  end

  // pointer table, written by load items
  always_ff @(posedge clk) begin
    if (acc && in_item.req_type == REQ_LOAD && in_item.slot < 4'(NUM_SLOTS)) begin
      ptab_r[in_item.slot] <= in_item.word;
    end
  end

endmodule

@@ hw/rtl/ebm_job_queue.sv @@
// Small job queue between the front end and the back end.
module ebm_job_queue #(
  parameter int unsigned DEPTH = ebm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ebm_pkg::job_push_t wr,
  output logic               q_full,
  input  logic               rd_pop,
  output logic               q_empty,
  output ebm_pkg::job_t      rd_data
);
  import ebm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr.valid && !q_full;
  assign do_rd   = rd_pop && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr.job;
    end
  end

endmodule

@@ hw/rtl/ebm_back.sv @@
// Back end: expands jobs into result items, splitting data at sector edges.
module ebm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ebm_pkg::job_t       q_rd_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output ebm_pkg::out_item_t  out_item
);
  import ebm_pkg::*;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  out_item_t   out_r, res;
  logic        out_valid_r;

  logic [8:0]  off;
  logic [22:0] sec;
  logic        split;
  logic [9:0]  pre;
  logic [10:0] tail_len;
  logic        out_free, fire, job_done;

  assign off      = job_r.addr[8:0];
  assign sec      = job_r.addr[31:9];
  assign split    = ({3'b000, off} + {1'b0, job_r.size}) > 12'(SECTOR_BYTES);
  assign pre      = 10'(SECTOR_BYTES) - {1'b0, off};
  assign tail_len = job_r.size - {1'b0, pre};

  assign out_free = !out_valid_r || pop;
  assign fire     = (state_r != BK_EMPTY) && out_free;
  assign job_done = fire && (state_r == BK_TAIL || job_r.kind == JOB_PTR || !split);
  assign q_pop    = !q_empty && (state_r == BK_EMPTY || job_done);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_EMPTY: begin
        if (q_pop) begin
          state_nxt = BK_HEAD;
        end
      end
      BK_HEAD, BK_TAIL: begin
        if (q_pop) begin
          state_nxt = BK_HEAD;
        end else if (job_done) begin
          state_nxt = BK_EMPTY;
        end else if (fire) begin
          state_nxt = BK_TAIL;
        end
      end
      default: state_nxt = BK_EMPTY;
    endcase
  end

  always_comb begin
    res = '0;
    case (state_r)
      BK_HEAD: begin
        if (job_r.kind == JOB_PTR) begin
          res.kind          = KIND_PTR;
          res.sector        = sec;
          res.sector_offset = off;
          res.length        = 10'd4;
        end else begin
          res.kind          = KIND_DATA;
          res.sector        = sec;
          res.sector_offset = off;
          res.length        = split ? pre : job_r.size[9:0];
          res.dest_offset   = job_r.dest;
          res.last          = split ? 1'b0 : job_r.last;
        end
      end
      BK_TAIL: begin
        res.kind          = KIND_DATA;
        res.sector        = sec + 23'd1;
        res.sector_offset = '0;
        res.length        = tail_len[9:0];
        res.dest_offset   = job_r.dest + {1'b0, pre};
        res.last          = job_r.last;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_rd_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

endmodule

@@ hw/rtl/ext2_block_map_translator.sv @@
// Top level of the ext2 block map translator: front end, job queue, back end.
// A result passes the front state, queue, back-end job and output registers in turn.
// Throughput: a load is taken without holding full; a translate or response holds full
//   while its one or two jobs go out, one job per cycle while the queue is not full.
// The back end gives one result per cycle while results are popped; a data job crossing a sector gives two.
// Reset (rst_n low, synchronous) empties queue and output; the table is not cleared.
module ext2_block_map_translator #(
  parameter int unsigned QUEUE_DEPTH = ebm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ebm_pkg::in_item_t   in_item,
  output logic                empty,
  input  logic                pop,
  output ebm_pkg::out_item_t  out_item
);
  import ebm_pkg::*;

  // front -> queue transfer of jobs
  job_push_t q_wr;
  logic      q_full;

  // queue -> back
  job_t      q_rd_data;
  logic      q_empty;
  logic      q_pop;

  // The front end decodes every item, owns the pointer table and the chase
  // state (phase, levels left, remaining index, pending second piece). It
  // turns each resolved piece or pointer fetch into one job.
  ebm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_wr    (q_wr),
    .q_full  (q_full)
  );

  // Decouples front and back so a stalled result consumer does not block
  // chase state updates until the queue fills.
  ebm_job_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .q_full  (q_full),
    .rd_pop  (q_pop),
    .q_empty (q_empty),
    .rd_data (q_rd_data)
  );

  // The back end converts byte addresses to sector/offset and splits data
  // reads at the 512-byte sector boundary into a registered output.
  ebm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd_data (q_rd_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result port not empty after reset");

  // front never pushes a job into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.valid |-> !q_full)
    else $error("job pushed into full queue");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // a data command never runs past its sector
  a_sector_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.kind == KIND_DATA) |->
      (({2'b00, out_item.sector_offset} + {1'b0, out_item.length}) <= 11'(SECTOR_BYTES)))
    else $error("data command crosses a sector boundary");

endmodule
